>>> src/battery_charge_estimator_top_assert.svh
// ----------------------------------------------------------------------------
// Battery charge estimator assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_ESTIMATOR_TOP_ASSERT_SVH
`define BATTERY_CHARGE_ESTIMATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BCE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bce_pkg.sv
// ----------------------------------------------------------------------------
// Battery charge estimator package
// Fixed field widths, gain reset value and the charge threshold ladder.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int MV_W   = 18;
    localparam int PCT_W  = 7;
    localparam int GAIN_W = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd13914;
    localparam logic [MV_W-1:0]   MV_MAX     = 18'd262143;

    localparam int RUNGS = 10;

    // Upper voltage bound of each 10 percent rung, in millivolts
    localparam logic [MV_W-1:0] RUNG_MV [RUNGS] = '{
        18'd45500, 18'd46040, 18'd46640, 18'd47240, 18'd47840,
        18'd48400, 18'd48960, 18'd49480, 18'd50000, 18'd50480
    };

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Map an average voltage to the first rung it does not exceed
    function automatic logic [PCT_W-1:0] ladder(input logic [MV_W-1:0] mv);
        logic [PCT_W-1:0] pct;
        pct = PCT_FULL;
        for (int k = RUNGS - 1; k >= 0; k--) begin
            if (mv <= RUNG_MV[k]) begin
                pct = PCT_W'(k * 10);
            end
        end
        return pct;
    endfunction

endpackage

>>> src/bce_if.sv
// ----------------------------------------------------------------------------
// Battery charge estimator channel interfaces
// Sample input, result output and gain configuration channels.
// ----------------------------------------------------------------------------
interface bce_sample_if #(
    parameter int W = 10
);
    logic         valid;
    logic         ready;
    logic [W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bce_result_if;
    logic                       valid;
    logic                       ready;
    logic [bce_pkg::MV_W-1:0]   avg_millivolts;
    logic [bce_pkg::PCT_W-1:0]  charge_percent;

    modport source (output valid, output avg_millivolts, output charge_percent, input ready);
    modport sink   (input valid, input avg_millivolts, input charge_percent, output ready);
endinterface

interface bce_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bce_pkg::GAIN_W-1:0]  mv_per_code_gain;

    modport source (output valid, output mv_per_code_gain, input ready);
    modport sink   (input valid, input mv_per_code_gain, output ready);
endinterface

>>> src/bce_ram.sv
// ----------------------------------------------------------------------------
// Battery charge estimator generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bce_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/battery_charge_estimator_top.sv
// ----------------------------------------------------------------------------
// Battery charge estimator
// Scales ADC samples to millivolts, keeps a moving average over a ring in
// RAM and maps the average to a charge percentage.
// ----------------------------------------------------------------------------
//  channel    dir  transaction
//  i_sample   in   one ADC sample
//  o_result   out  average millivolts and charge percent
//  i_cfg      in   gain write, always ready
//
//  Each sample runs to completion before the next is accepted: read and
//  scale, accumulate and write back, then a restoring divider that yields
//  one quotient bit per cycle over the TOT_W-bit total.
//  A result waits in the output register while the next sample is taken; a
//  finished division holds until that register is free. Reset empties the
//  window at once through the fill count, so no clearing pass is needed.
module battery_charge_estimator_top #(
    parameter int WINDOW   = 10,
    parameter int ADC_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bce_sample_if.sink    i_sample,
    bce_result_if.source  o_result,
    bce_cfg_if.sink       i_cfg
);

    localparam int MV_W   = bce_pkg::MV_W;
    localparam int GAIN_W = bce_pkg::GAIN_W;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int TOT_W  = MV_W + $clog2(WINDOW);
    localparam int PROD_W = ADC_BITS + GAIN_W;
    localparam int BIT_W  = $clog2(TOT_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_ACCUM,
        S_DIVIDE,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [GAIN_W-1:0]        r_gain;
    logic [ADC_BITS-1:0]      r_sample;
    logic [MV_W-1:0]          r_scaled;
    logic [MV_W-1:0]          r_old;
    logic [SLOT_W-1:0]        r_slot;
    logic [CNT_W-1:0]         r_filled;
    logic [TOT_W-1:0]         r_total;
    logic [TOT_W-1:0]         r_dividend;
    logic [CNT_W-1:0]         r_rem;
    logic [BIT_W-1:0]         r_bit;
    logic                     r_out_valid;
    logic [MV_W-1:0]          r_avg;
    logic [bce_pkg::PCT_W-1:0] r_pct;

    logic                     w_accept;
    logic                     w_full;
    logic [MV_W-1:0]          w_rdata;
    logic [PROD_W-1:0]        w_prod;
    logic [PROD_W-1:0]        w_shift;
    logic [CNT_W:0]           w_trial;
    logic [CNT_W:0]           w_sub;
    logic                     w_ge;
    logic [MV_W-1:0]          w_avg;
    logic                     w_out_free;
    logic                     w_load;

    assign w_accept   = i_sample.valid && i_sample.ready;
    assign w_full     = (r_filled == CNT_W'(WINDOW));
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_load     = (r_state == S_DONE) && w_out_free;

    // Scale: product then Q8 shift
    assign w_prod  = PROD_W'(r_sample) * PROD_W'(r_gain);
    assign w_shift = w_prod >> 8;

    // Divider step: shift in the next dividend bit, try the subtract
    assign w_trial = {r_rem, r_dividend[TOT_W-1]};
    assign w_sub   = w_trial - (CNT_W + 1)'(r_filled);
    assign w_ge    = (w_trial >= (CNT_W + 1)'(r_filled));

    // Clamp the quotient to the output range
    assign w_avg = (r_dividend > TOT_W'(bce_pkg::MV_MAX)) ? bce_pkg::MV_MAX
                                                          : r_dividend[MV_W-1:0];

    // Ring of scaled samples; written back before the next read, so no overlap
    bce_ram #(
        .WIDTH (MV_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_ACCUM),
        .i_waddr (r_slot),
        .i_wdata (r_scaled),
        .i_re    (w_accept),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    // Sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= bce_pkg::GAIN_RESET;
            r_slot      <= '0;
            r_filled    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Take gain writes
            if (i_cfg.valid) begin
                r_gain <= i_cfg.mv_per_code_gain;
            end

            // Load a new result, or drop the current one once taken
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sample <= i_sample.adc_sample;
                        r_state  <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_scaled <= (w_shift > PROD_W'(bce_pkg::MV_MAX)) ? bce_pkg::MV_MAX
                                                                     : w_shift[MV_W-1:0];
                    // Slots beyond the fill count were never written and count as zero
                    r_old    <= w_full ? w_rdata : '0;
                    r_state  <= S_ACCUM;
                end
                S_ACCUM: begin
                    r_total    <= r_total + TOT_W'(r_scaled) - TOT_W'(r_old);
                    r_dividend <= r_total + TOT_W'(r_scaled) - TOT_W'(r_old);
                    r_rem      <= '0;
                    r_bit      <= BIT_W'(TOT_W - 1);
                    r_slot     <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    if (!w_full) begin
                        r_filled <= r_filled + 1'b1;
                    end
                    r_state    <= S_DIVIDE;
                end
                S_DIVIDE: begin
                    r_rem      <= w_ge ? w_sub[CNT_W-1:0] : w_trial[CNT_W-1:0];
                    r_dividend <= {r_dividend[TOT_W-2:0], w_ge};
                    r_bit      <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (w_out_free) begin
                        r_avg       <= w_avg;
                        r_pct       <= bce_pkg::ladder(w_avg);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_sample.ready          = (r_state == S_IDLE);
    assign i_cfg.ready             = 1'b1;
    assign o_result.valid          = r_out_valid;
    assign o_result.avg_millivolts = r_avg;
    assign o_result.charge_percent = r_pct;

endmodule

>>> src/bce_checker.sv
// ----------------------------------------------------------------------------
// Battery charge estimator port checker
// Watches the top-level channels for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "battery_charge_estimator_top_assert.svh"

module bce_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [bce_pkg::MV_W-1:0]   i_avg,
    input logic [bce_pkg::PCT_W-1:0]  i_pct
);

    // Stalled result holds
    `BCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_avg) && $stable(i_pct), "result changed while stalled")

    // One sample at a time: busy right after a transaction
    `BCE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "sample taken while busy")

    // Empty rung only at or below the lowest threshold
    `BCE_ASSERT_SAME(a_pct_empty, i_clk, i_rst_n, i_out_valid && (i_pct == 7'd0), i_avg <= 18'd45500, "zero percent above lowest rung")

    // Full charge only above the top threshold
    `BCE_ASSERT_SAME(a_pct_full, i_clk, i_rst_n, i_out_valid && (i_pct == 7'd100), i_avg > 18'd50480, "full charge below top rung")

endmodule

bind battery_charge_estimator_top bce_checker u_bce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_avg       (o_result.avg_millivolts),
    .i_pct       (o_result.charge_percent)
);

>>> tb/battery_charge_estimator_top_tb.sv
// ----------------------------------------------------------------------------
// Battery charge estimator testbench
// Streams ADC samples through the gauge under several gain settings, random
// source gaps and sink stalls. A scoreboard predicts the moving average and
// the charge rung for each accepted sample and checks every result in order.
// ----------------------------------------------------------------------------
module battery_charge_estimator_top_tb;

    localparam int MV_W   = bce_pkg::MV_W;
    localparam int PCT_W  = bce_pkg::PCT_W;
    localparam int GAIN_W = bce_pkg::GAIN_W;
    localparam logic [MV_W-1:0] MV_MAX = bce_pkg::MV_MAX;

    localparam int ADC_W        = 10;
    localparam int WIN          = 10;
    localparam int SAMPLE_ITEMS = 1900;
    localparam int CALM_ITEMS   = 1700;
    localparam int TIMEOUT_CYC  = 800_000;

    localparam logic [GAIN_W-1:0] GAIN_DEFAULT = 16'd13914;

    // Upper voltage bound of each charge rung, 0 to 90 percent
    localparam logic [MV_W-1:0] RUNG_LIMIT_MV [10] = '{
        18'd45500, 18'd46040, 18'd46640, 18'd47240, 18'd47840,
        18'd48400, 18'd48960, 18'd49480, 18'd50000, 18'd50480
    };

    typedef enum int {
        MODE_RUNG,
        MODE_NOMINAL,
        MODE_WIDE,
        MODE_CORNER
    } t_phase_mode;

    typedef struct {
        logic [MV_W-1:0]  avg_mv;
        logic [PCT_W-1:0] pct;
    } t_gauge_reading;

    // Shadow gauge: gain, sample window and queue of predicted readings
    class charge_scoreboard;
        logic [GAIN_W-1:0] gain;
        logic [MV_W-1:0]   window_mv [WIN];
        int                slot;
        int                filled;
        logic [21:0]       total_mv;
        t_gauge_reading    readings [$];
        int                mismatches;
        int                checked;

        function new();
            gain       = GAIN_DEFAULT;
            slot       = 0;
            filled     = 0;
            total_mv   = '0;
            mismatches = 0;
            checked    = 0;
            foreach (window_mv[i]) window_mv[i] = '0;
        endfunction

        function void set_gain(logic [GAIN_W-1:0] g);
            gain = g;
        endfunction

        function int pending();
            return readings.size();
        endfunction

        function logic [PCT_W-1:0] rung_percent(logic [MV_W-1:0] mv);
            for (int k = 0; k < 10; k++) begin
                if (mv <= RUNG_LIMIT_MV[k]) begin
                    return PCT_W'(k * 10);
                end
            end
            return 7'd100;
        endfunction

        // Scale the sample, slide the window and queue the new reading
        function void note_sample(logic [ADC_W-1:0] s);
            logic [25:0]     prod;
            logic [MV_W-1:0] scaled;
            logic [21:0]     avg;
            t_gauge_reading  r;
            prod   = 26'(s) * 26'(gain);
            scaled = prod[25:8];
            total_mv = total_mv - 22'(window_mv[slot]) + 22'(scaled);
            window_mv[slot] = scaled;
            slot = (slot + 1 >= WIN) ? 0 : slot + 1;
            if (filled < WIN) begin
                filled++;
            end
            avg = total_mv / 22'(filled);
            if (avg > 22'(MV_MAX)) begin
                avg = 22'(MV_MAX);
            end
            r.avg_mv = avg[MV_W-1:0];
            r.pct    = rung_percent(avg[MV_W-1:0]);
            readings.push_back(r);
        endfunction

        task report(string what);
            $display("ERROR: %s", what);
            mismatches++;
        endtask

        // Compare one result transaction against the oldest prediction
        task check_result(logic [MV_W-1:0] mv, logic [PCT_W-1:0] pct);
            t_gauge_reading r;
            if (readings.size() == 0) begin
                report($sformatf("unexpected result mv=%0d pct=%0d", mv, pct));
            end else begin
                r = readings.pop_front();
                if (mv !== r.avg_mv) begin
                    report($sformatf("result %0d avg_millivolts %0d, want %0d",
                                     checked, mv, r.avg_mv));
                end
                if (pct !== r.pct) begin
                    report($sformatf("result %0d charge_percent %0d, want %0d",
                                     checked, pct, r.pct));
                end
            end
            checked++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bce_sample_if #(.W(ADC_W)) smp_if ();
    bce_result_if              res_if ();
    bce_cfg_if                 cfg_if ();

    battery_charge_estimator_top #(
        .WINDOW   (WIN),
        .ADC_BITS (ADC_W)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    charge_scoreboard sb = new();

    int samples_sent = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int stall_left   = 0;
    bit calm         = 1'b0;

    always #5 i_clk = ~i_clk;

    // Sink side: stall in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (!calm && stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            stall_left   <= $urandom_range(9, 0);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.avg_millivolts, res_if.charge_percent);
        end
    end

    // Offer one sample, with an optional gap, and hold until accepted
    task automatic send_sample(input logic [ADC_W-1:0] s);
        int gap;
        gap = 0;
        if (!calm && gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(10, 1);
        end
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid      <= 1'b1;
        smp_if.adc_sample <= s;
        do @(posedge i_clk); while (!smp_if.ready);
        sb.note_sample(s);
        samples_sent++;
        if (samples_sent >= CALM_ITEMS) begin
            calm = 1'b1;
        end
    endtask

    // Stop sending and wait until every predicted reading has come back
    task automatic drain();
        smp_if.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // Write the gain register while the block is idle
    task automatic write_gain(input logic [GAIN_W-1:0] g);
        drain();
        cfg_if.valid            <= 1'b1;
        cfg_if.mv_per_code_gain <= g;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sb.set_gain(g);
    endtask

    // One random phase: pick a gain regime and stream samples in it
    task automatic run_phase();
        t_phase_mode      mode;
        int               pick;
        int               len;
        int               rung;
        logic [GAIN_W-1:0] g;
        logic [ADC_W-1:0]  s;
        pick = $urandom_range(99);
        if (pick < 30)      mode = MODE_RUNG;
        else if (pick < 65) mode = MODE_NOMINAL;
        else if (pick < 90) mode = MODE_WIDE;
        else                mode = MODE_CORNER;

        case (mode)
            MODE_RUNG: begin
                rung = $urandom_range(9, 0);
                g    = RUNG_LIMIT_MV[rung][GAIN_W-1:0];
            end
            MODE_NOMINAL: g = GAIN_W'($urandom_range(15400, 12400));
            MODE_WIDE:    g = GAIN_W'($urandom);
            default: begin
                case ($urandom_range(4))
                    0:       g = 16'd0;
                    1:       g = 16'd1;
                    2:       g = 16'hFFFF;
                    3:       g = 16'hFFFE;
                    default: g = GAIN_DEFAULT;
                endcase
            end
        endcase
        write_gain(g);

        case ($urandom_range(2))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            default: gap_pct = 40;
        endcase
        case ($urandom_range(2))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            default: stall_pct = 40;
        endcase

        // Sample 256 with gain equal to a rung limit scales exactly onto it
        if (mode == MODE_RUNG) begin
            repeat (WIN) send_sample(10'd256);
        end
        len = $urandom_range(60, 20);
        for (int n = 0; n < len; n++) begin
            case (mode)
                MODE_RUNG:    s = ADC_W'($urandom_range(264, 248));
                MODE_NOMINAL: s = ADC_W'($urandom_range(1000, 780));
                MODE_WIDE:    s = ADC_W'($urandom_range(1023, 0));
                default: begin
                    case ($urandom_range(3))
                        0:       s = '0;
                        1:       s = '1;
                        default: s = ADC_W'($urandom_range(1023, 0));
                    endcase
                end
            endcase
            send_sample(s);
        end
    endtask

    // Main sequence: reset, directed samples, random phases, wind down
    initial begin
        i_rst_n                 <= 1'b0;
        smp_if.valid            <= 1'b0;
        smp_if.adc_sample       <= '0;
        cfg_if.valid            <= 1'b0;
        cfg_if.mv_per_code_gain <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Partly filled window at the reset gain, then full and wrapping
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd512);
        send_sample(10'd1);
        send_sample(10'd837);
        send_sample(10'd846);
        send_sample(10'd929);
        send_sample(10'd930);
        send_sample(10'd1023);
        send_sample(10'd0);

        // Largest gain, then zero gain
        write_gain(16'hFFFF);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd1023);
        write_gain(16'd0);
        send_sample(10'd1023);
        send_sample(10'd512);

        while (samples_sent < SAMPLE_ITEMS) begin
            run_phase();
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop on a hang
    initial begin
        #(TIMEOUT_CYC * 10);
        $display("Mismatches found");
        $finish;
    end

endmodule
